// ----- design/winsorized_variance_macros.svh -----
// Assertion macros shared by the winsorized variance checker.
`ifndef WINSORIZED_VARIANCE_MACROS_SVH
`define WINSORIZED_VARIANCE_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off while in reset.
`define WV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off while in reset.
`define WV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wv_pkg.sv -----
// Shared types, widths and constants of the winsorized variance block.
package wv_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int SMP_W       = 16;
    localparam int TRIM_W      = 16;
    localparam int CNT_W       = 13;
    localparam int CFG_W       = 16;
    localparam int VAR_W       = 39;
    localparam int SUM_W       = 29;
    localparam int SQ_W        = 44;
    localparam int ABS_W       = 28;
    localparam int DEN_W       = 24;
    localparam int NUM_W       = 57;
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 16;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int FRAC_W      = 8;
    localparam int QUO_W       = VAR_W;
    localparam int DIV_SH      = QUO_W - FRAC_W;
    localparam int DIV_CNT_W   = $clog2(QUO_W + 1);

    localparam logic [TRIM_W-1:0] HALF_TRIM = TRIM_W'(32768);
    localparam logic [VAR_W-1:0]  VAR_MAX   = {VAR_W{1'b1}};
    localparam logic [CNT_W-1:0]  MIN_N     = CNT_W'(2);
    localparam logic [CNT_W-1:0]  MAX_N     = CNT_W'(MAX_SAMPLES);

    typedef enum logic [0:0] {
        REG_TRIM  = 1'b0,
        REG_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CFG_MUL,
        S_CFG_DEN,
        S_CFG_HIGH,
        S_SQ,
        S_WSQ,
        S_WX,
        S_ACC,
        S_ABS,
        S_S2_LO,
        S_S2_HI,
        S_NSS_LO,
        S_NSS_HI,
        S_NSS_SUM,
        S_DIFF,
        S_SAT,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ----- design/wv_mul.sv -----
// Shared unsigned multiplier with a registered product.
module wv_mul (
    input  logic                        i_clk,
    input  logic [wv_pkg::MUL_A_W-1:0]  i_a,
    input  logic [wv_pkg::MUL_B_W-1:0]  i_b,
    output logic [wv_pkg::MUL_P_W-1:0]  o_p
);
    import wv_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- design/wv_div.sv -----
// Restoring divider, one quotient bit per cycle, 8 fraction bits appended.
module wv_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wv_pkg::NUM_W-1:0]  i_num,
    input  logic [wv_pkg::DEN_W-1:0]  i_den,
    output logic                      o_done,
    output logic [wv_pkg::QUO_W-1:0]  o_quo
);
    import wv_pkg::*;

    logic [DEN_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_sh;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;

    // Shift in the next numerator bit, subtract the divisor when it fits.
    always_comb begin
        w_trial = {r_rem, r_sh[QUO_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // Caller guarantees the quotient fits, so the top part is below the divisor.
                r_rem  <= i_num[DIV_SH +: DEN_W];
                r_sh   <= {i_num[DIV_SH-1:0], {FRAC_W{1'b0}}};
                r_den  <= i_den;
                r_cnt  <= DIV_CNT_W'(QUO_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_sh  <= {r_sh[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;

endmodule

// ----- design/winsorized_variance.sv -----
// Top level of the winsorized variance block: sequencer, sums and output register.
//
// Usage: one set of sorted signed 16-bit samples enters on the input channel
// (i_in_valid / o_in_stall / i_sample), one sample per item, lowest first.
// After the last sample of a set, one result leaves on the output channel
// (o_out_valid / i_out_stall / o_variance / o_fully_trimmed).
// Configuration: i_wr_en with i_wr_index and i_wr_data writes the trim
// fraction or the set size; any write drops the set in progress, then the
// block works out the trim bounds and n*(n-1) in S_CFG_MUL .. S_CFG_HIGH.
// Processing: a sample that carries weight is accepted, then passes through
// S_SQ, S_WSQ, S_WX and S_ACC on the shared multiplier and accumulator;
// a trimmed-off sample is only accepted. The last sample of a set then goes
// through |S|, four multiplier passes and a sum for S^2 and n*SS, the
// difference and range check, the bit-serial divider (39 quotient bits,
// then done), then the load of the output register. Fully trimmed sets skip
// all of that and go from the last sample straight to the output load.
// A waiting result sits in the output register while the next set streams
// in; only the next result waits for a stall to clear.
// Reset (synchronous, active low) restores trim 0 and set size 2, clears
// the sums and drops any result not yet taken.
module winsorized_variance (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  wv_pkg::t_reg_idx             i_wr_index,
    input  logic [wv_pkg::CFG_W-1:0]     i_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [wv_pkg::SMP_W-1:0] i_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [wv_pkg::VAR_W-1:0]     o_variance,
    output logic                         o_fully_trimmed
);
    import wv_pkg::*;

    t_state r_state;
    t_state n_state;

    // Configuration and derived bounds
    logic [TRIM_W-1:0] r_trim;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ilow;
    logic [CNT_W-1:0]  r_ihigh;
    logic [DEN_W-1:0]  r_den;

    // Running set state
    logic [CNT_W-1:0]        r_index;
    logic signed [SUM_W-1:0] r_val_sum;
    logic [SQ_W-1:0]         r_sq_sum;

    // Current sample
    logic [SMP_W-1:0] r_mag;
    logic             r_neg;
    logic [CNT_W-1:0] r_wt;
    logic             r_last;

    // Finish path
    logic [ABS_W-1:0] r_abs;
    logic [NUM_W-1:0] r_acc;
    logic [NUM_W-1:0] r_s2;
    logic [NUM_W-1:0] r_num;
    logic [VAR_W-1:0] r_res_var;
    logic             r_res_ft;

    // Output register
    logic             r_out_valid;
    logic [VAR_W-1:0] r_out_var;
    logic             r_out_ft;

    logic [CNT_W-1:0]   w_n;
    logic               w_full;
    logic               w_last;
    logic [CNT_W-1:0]   w_wt;
    logic [SMP_W-1:0]   w_mag;
    logic               w_sat;
    logic               w_out_free;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    logic               w_div_start;
    logic               w_div_done;
    logic [QUO_W-1:0]   w_quo;
    logic [SUM_W-1:0]   w_sum_neg;

    wv_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    wv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Clamp the set size into the supported range.
    always_comb begin
        if (r_count < MIN_N) begin
            w_n = MIN_N;
        end else if (r_count > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = r_count;
        end
    end

    assign w_full     = (r_trim >= HALF_TRIM);
    assign w_last     = (r_index >= w_n - CNT_W'(1));
    assign w_mag      = i_sample[SMP_W-1] ? SMP_W'(-i_sample) : SMP_W'(i_sample);
    assign w_sat      = (r_num >= NUM_W'({r_den, {DIV_SH{1'b0}}}));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_sum_neg  = -r_val_sum;

    // Weight of the sample at the current position: the edge samples stand in
    // for the trimmed ones, and a lone middle sample stands in for all of them.
    always_comb begin
        w_wt = '0;
        if (!w_full) begin
            if (r_index == r_ilow && r_index == r_ihigh) begin
                w_wt = w_n;
            end else if (r_index == r_ilow || r_index == r_ihigh) begin
                w_wt = r_ilow + CNT_W'(1);
            end else if (r_index > r_ilow && r_index < r_ihigh) begin
                w_wt = CNT_W'(1);
            end
        end
    end

    // Hold off input while busy, while a register is written and in reset.
    assign o_in_stall = (r_state != S_IDLE) || i_wr_en || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, multiplier operands, divider start.
    always_comb begin
        n_state     = r_state;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        if (i_wr_en) begin
            n_state = S_CFG_MUL;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (w_full) begin
                            n_state = w_last ? S_OUT : S_IDLE;
                        end else if (w_wt != '0) begin
                            n_state = S_SQ;
                        end else begin
                            n_state = w_last ? S_ABS : S_IDLE;
                        end
                    end
                end
                S_CFG_MUL: begin
                    w_mul_a = MUL_A_W'(r_trim);
                    w_mul_b = MUL_B_W'(w_n);
                    n_state = S_CFG_DEN;
                end
                S_CFG_DEN: begin
                    w_mul_a = MUL_A_W'(w_n);
                    w_mul_b = MUL_B_W'(w_n - CNT_W'(1));
                    n_state = S_CFG_HIGH;
                end
                S_CFG_HIGH: begin
                    n_state = S_IDLE;
                end
                S_SQ: begin
                    w_mul_a = MUL_A_W'(r_mag);
                    w_mul_b = MUL_B_W'(r_mag);
                    n_state = S_WSQ;
                end
                S_WSQ: begin
                    w_mul_a = w_prod[MUL_A_W-1:0];
                    w_mul_b = MUL_B_W'(r_wt);
                    n_state = S_WX;
                end
                S_WX: begin
                    w_mul_a = MUL_A_W'(r_mag);
                    w_mul_b = MUL_B_W'(r_wt);
                    n_state = S_ACC;
                end
                S_ACC: begin
                    n_state = r_last ? S_ABS : S_IDLE;
                end
                S_ABS: begin
                    n_state = S_S2_LO;
                end
                S_S2_LO: begin
                    w_mul_a = MUL_A_W'(r_abs);
                    w_mul_b = r_abs[MUL_B_W-1:0];
                    n_state = S_S2_HI;
                end
                S_S2_HI: begin
                    w_mul_a = MUL_A_W'(r_abs);
                    w_mul_b = MUL_B_W'(r_abs[ABS_W-1:MUL_B_W]);
                    n_state = S_NSS_LO;
                end
                S_NSS_LO: begin
                    w_mul_a = r_sq_sum[MUL_A_W-1:0];
                    w_mul_b = MUL_B_W'(w_n);
                    n_state = S_NSS_HI;
                end
                S_NSS_HI: begin
                    w_mul_a = MUL_A_W'(r_sq_sum[SQ_W-1:MUL_A_W]);
                    w_mul_b = MUL_B_W'(w_n);
                    n_state = S_NSS_SUM;
                end
                S_NSS_SUM: begin
                    n_state = S_DIFF;
                end
                S_DIFF: begin
                    n_state = S_SAT;
                end
                S_SAT: begin
                    if (w_sat) begin
                        n_state = S_OUT;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        n_state = S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, advanced by the sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim      <= '0;
            r_count     <= MIN_N;
            r_ilow      <= '0;
            r_ihigh     <= CNT_W'(1);
            r_den       <= DEN_W'(2);
            r_index     <= '0;
            r_val_sum   <= '0;
            r_sq_sum    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop a taken result unless a new one loads in the same cycle.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT || i_wr_en)) begin
                r_out_valid <= 1'b0;
            end
            if (i_wr_en) begin
                // Drop the set in progress on any register write.
                unique case (i_wr_index)
                    REG_TRIM:  r_trim  <= i_wr_data[TRIM_W-1:0];
                    REG_COUNT: r_count <= i_wr_data[CNT_W-1:0];
                    default:   r_trim  <= r_trim;
                endcase
                r_index   <= '0;
                r_val_sum <= '0;
                r_sq_sum  <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_mag     <= w_mag;
                            r_neg     <= i_sample[SMP_W-1];
                            r_wt      <= w_wt;
                            r_last    <= w_last;
                            r_index   <= w_last ? '0 : r_index + CNT_W'(1);
                            r_res_var <= '0;
                            r_res_ft  <= 1'b1;
                        end
                    end
                    S_CFG_DEN: begin
                        r_ilow <= w_prod[TRIM_W +: CNT_W];
                    end
                    S_CFG_HIGH: begin
                        r_den   <= w_prod[DEN_W-1:0];
                        r_ihigh <= w_n - CNT_W'(1) - r_ilow;
                    end
                    S_WX: begin
                        r_sq_sum <= r_sq_sum + w_prod[SQ_W-1:0];
                    end
                    S_ACC: begin
                        if (r_neg) begin
                            r_val_sum <= r_val_sum - $signed({1'b0, w_prod[SUM_W-2:0]});
                        end else begin
                            r_val_sum <= r_val_sum + $signed({1'b0, w_prod[SUM_W-2:0]});
                        end
                    end
                    S_ABS: begin
                        r_abs <= r_val_sum[SUM_W-1] ? w_sum_neg[ABS_W-1:0]
                                                    : r_val_sum[ABS_W-1:0];
                    end
                    S_S2_HI: begin
                        r_acc <= NUM_W'(w_prod);
                    end
                    S_NSS_LO: begin
                        r_s2 <= r_acc + (NUM_W'(w_prod) << MUL_B_W);
                    end
                    S_NSS_HI: begin
                        r_acc <= NUM_W'(w_prod);
                    end
                    S_NSS_SUM: begin
                        r_acc <= r_acc + (NUM_W'(w_prod) << MUL_A_W);
                    end
                    S_DIFF: begin
                        // n*SS - S^2, floored at zero
                        r_num <= (r_acc > r_s2) ? r_acc - r_s2 : '0;
                    end
                    S_SAT: begin
                        r_res_var <= VAR_MAX;
                        r_res_ft  <= 1'b0;
                    end
                    S_DIV: begin
                        if (w_div_done) begin
                            r_res_var <= w_quo;
                        end
                    end
                    S_OUT: begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_var   <= r_res_var;
                            r_out_ft    <= r_res_ft;
                            r_val_sum   <= '0;
                            r_sq_sum    <= '0;
                        end
                    end
                    default: begin
                        r_index <= r_index;
                    end
                endcase
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_variance      = r_out_var;
    assign o_fully_trimmed = r_out_ft;

endmodule

// ----- design/wv_checker.sv -----
// Port-level checker for the winsorized variance block and its bind.
`include "winsorized_variance_macros.svh"

module wv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_wr_en,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [wv_pkg::VAR_W-1:0]        o_variance,
    input logic                            o_fully_trimmed
);
    import wv_pkg::*;

    // Hold a stalled result.
    `WV_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_variance) && $stable(o_fully_trimmed), "stalled result changed")

    // A fully trimmed set reports zero variance.
    `WV_ASSERT_NOW(a_trim_zero, o_out_valid && o_fully_trimmed, o_variance == '0, "fully trimmed result with nonzero variance")

    // A register write sends the block into its setup pass.
    `WV_ASSERT_NEXT(a_cfg_busy, i_wr_en, o_in_stall, "input taken right after a register write")

    // Never take input while a register is written.
    `WV_ASSERT_NOW(a_cfg_stall, i_wr_en && i_in_valid, o_in_stall, "input taken during a register write")

    // A new result is only loaded out of a finish step with input held off.
    `WV_ASSERT_NOW(a_out_after_busy, $rose(o_out_valid), $past(o_in_stall), "result appeared without a finish step")

endmodule

bind winsorized_variance wv_checker u_wv_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the winsorized variance block.
module tb;
    import wv_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic             fully_trimmed;
    } variance_t;

    // Settle time before a register write. It covers the last weighted
    // sample plus the finish pipeline of a set that gave no result.
    localparam int   SETTLE_CYCLES = 80;
    localparam int   RANDOM_ITEMS  = 1150;
    localparam u64_t TIMEOUT_UNITS = 64'd20_000_000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    wr_en = 1'b0;
    t_reg_idx                wr_index = REG_TRIM;
    logic [CFG_W-1:0]        wr_data = '0;
    logic                    in_valid = 1'b0;
    logic signed [SMP_W-1:0] sample_drv = '0;
    logic                    out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [VAR_W-1:0]        o_variance;
    logic                    o_fully_trimmed;

    winsorized_variance DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (wr_en),
        .i_wr_index      (wr_index),
        .i_wr_data       (wr_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (sample_drv),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_variance      (o_variance),
        .o_fully_trimmed (o_fully_trimmed)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Samples waiting to be driven, and variances owed by the block.
    logic signed [SMP_W-1:0] sample_queue[$];
    variance_t               variance_queue[$];

    // Shadow copy of the configuration and the running sums of the set.
    logic [TRIM_W-1:0] trim_reg = '0;
    logic [CNT_W-1:0]  count_reg = CNT_W'(2);
    u64_t              set_pos = 0;
    longint            wsum = 0;
    u64_t              wsq = 0;

    bit   idle_on = 1'b0;
    int   in_gap = 0;
    int   stall_left = 0;
    int   err_count = 0;
    int   samples_sent = 0;
    int   sets_checked = 0;
    int   full_results = 0;
    int   reg_writes = 0;

    // Effective set size: clamp the register into 2 .. MAX_SAMPLES.
    function automatic u64_t set_size();
        u64_t n;
        n = u64_t'(count_reg);
        if (n < 2) n = 2;
        if (n > u64_t'(MAX_SAMPLES)) n = u64_t'(MAX_SAMPLES);
        return n;
    endfunction

    // Weight one sample into the sums; on the last sample of a set, work out
    // the unbiased variance (n*SS - S^2) / (n*(n-1)) with 8 fraction bits.
    function automatic void fold_sample(logic signed [SMP_W-1:0] smp);
        u64_t      n, ilow, ihigh, w, mag, s2, nss, d, den, q, r, v;
        longint    xs;
        variance_t res;
        n = set_size();
        xs = longint'(smp);
        w = 0;
        if (trim_reg < HALF_TRIM) begin
            ilow = (u64_t'(trim_reg) * n) >> 16;
            ihigh = n - 1 - ilow;
            if (set_pos == ilow && set_pos == ihigh) begin
                w = n;
            end else if (set_pos == ilow || set_pos == ihigh) begin
                w = ilow + 1;
            end else if (set_pos > ilow && set_pos < ihigh) begin
                w = 1;
            end
        end
        if (w != 0) begin
            mag = (xs < 0) ? u64_t'(-xs) : u64_t'(xs);
            wsum += longint'(w) * xs;
            wsq += w * mag * mag;
        end
        if (set_pos + 1 >= n) begin
            v = 0;
            if (trim_reg < HALF_TRIM) begin
                mag = (wsum < 0) ? u64_t'(-wsum) : u64_t'(wsum);
                s2 = mag * mag;
                nss = n * wsq;
                if (nss > s2) begin
                    d = nss - s2;
                    den = n * (n - 1);
                    q = d / den;
                    r = d % den;
                    if (q > (u64_t'(VAR_MAX) >> FRAC_W)) begin
                        v = u64_t'(VAR_MAX);
                    end else begin
                        v = (q << FRAC_W) + ((r << FRAC_W) / den);
                        if (v > u64_t'(VAR_MAX)) v = u64_t'(VAR_MAX);
                    end
                end
            end
            res.variance = VAR_W'(v);
            res.fully_trimmed = (trim_reg >= HALF_TRIM);
            variance_queue.push_back(res);
            set_pos = 0;
            wsum = 0;
            wsq = 0;
        end else begin
            set_pos = set_pos + 1;
        end
    endfunction

    // Input driver: fold each accepted item into the prediction, then load
    // the next one from the queue, or hold idle for the rest of a burst.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                fold_sample(sample_drv);
                samples_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_valid <= 1'b0;
                    in_gap--;
                end else if (sample_queue.size() != 0) begin
                    in_valid <= 1'b1;
                    sample_drv <= sample_queue.pop_front();
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        in_gap = $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest owed
    // variance, and throw random stall bursts at the output.
    always @(posedge i_clk) begin
        variance_t owed;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (variance_queue.size() == 0) begin
                    $error("unexpected result: variance %0d fully_trimmed %0b",
                           o_variance, o_fully_trimmed);
                    err_count++;
                end else begin
                    owed = variance_queue.pop_front();
                    sets_checked++;
                    if (owed.fully_trimmed) full_results++;
                    if (o_variance !== owed.variance) begin
                        $error("variance: expected %0d, actual %0d",
                               owed.variance, o_variance);
                        err_count++;
                    end
                    if (o_fully_trimmed !== owed.fully_trimmed) begin
                        $error("fully_trimmed: expected %0b, actual %0b",
                               owed.fully_trimmed, o_fully_trimmed);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 9);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Wait until every item is taken and every owed result is out, then let
    // the block finish any set that gave no result.
    task automatic drain();
        while (sample_queue.size() != 0 || in_valid || variance_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle; any write drops the set.
    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge i_clk);
        wr_en <= 1'b0;
        if (idx == REG_TRIM) begin
            trim_reg = data[TRIM_W-1:0];
        end else begin
            count_reg = data[CNT_W-1:0];
        end
        set_pos = 0;
        wsum = 0;
        wsq = 0;
        reg_writes++;
    endtask

    task automatic push_samples(int cnt);
        int mode, v, stepmax;
        mode = $urandom_range(0, 9);
        // Start low for wide sorted sets, anywhere for narrow clusters.
        if (mode <= 3) begin
            v = (mode == 0) ? -32768 : int'($urandom_range(0, 4000)) - 32768;
            stepmax = 65535 / cnt + 1;
        end else if (mode <= 7) begin
            v = int'($urandom_range(0, 65535)) - 32768;
            stepmax = $urandom_range(0, 300);
        end else begin
            v = int'($urandom_range(0, 65535)) - 32768;
            stepmax = 0;
        end
        for (int k = 0; k < cnt; k++) begin
            // Unsorted noise in mode 9: every sample drawn on its own.
            if (mode == 9) v = int'($urandom_range(0, 65535)) - 32768;
            sample_queue.push_back(SMP_W'(v));
            v += int'($urandom_range(0, stepmax));
            if (v > 32767) v = 32767;
        end
    endtask

    task automatic push_list(input int vals[$]);
        foreach (vals[k]) sample_queue.push_back(SMP_W'(vals[k]));
    endtask

    initial begin
        int   rand_items;
        int   n;
        int   nsets;
        logic [TRIM_W-1:0] trim_pick;
        logic [CFG_W-1:0]  count_data;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (no trim, pairs): span the whole sample range.
        push_list('{-32768, 32767, 0, 0, -1, 0});
        drain();

        // Trim just under one half with an odd set: the middle sample alone
        // carries the whole weight, so the variance is zero.
        write_reg(REG_COUNT, CFG_W'(3));
        write_reg(REG_TRIM, TRIM_W'(32767));
        push_list('{-5, 100, 32767});
        drain();

        // Fully trimmed at the top trim value, with a set size below the floor.
        write_reg(REG_TRIM, 16'hFFFF);
        write_reg(REG_COUNT, CFG_W'(0));
        push_list('{-32768, 32767});
        drain();

        // Fully trimmed at exactly one half; set size 1 acts as 2.
        write_reg(REG_TRIM, HALF_TRIM);
        write_reg(REG_COUNT, CFG_W'(1));
        push_list('{123, 4567});
        drain();

        // Drop a set half way through with a register write.
        write_reg(REG_TRIM, '0);
        write_reg(REG_COUNT, CFG_W'(5));
        push_list('{-9, 3, 40});
        drain();
        write_reg(REG_TRIM, TRIM_W'(13108));
        push_list('{-300, -2, 7, 7, 9000});
        drain();

        // Upper data bits above the count field are ignored; one per end.
        write_reg(REG_COUNT, 16'hE004);
        write_reg(REG_TRIM, TRIM_W'(16384));
        push_list('{-32768, -7, 12, 32767});
        drain();

        // Random phases: new settings, a few well-formed sets, sometimes a
        // broken tail that the next write drops.
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            idle_on = (rand_items < RANDOM_ITEMS - 150) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0: trim_pick = '0;
                1: trim_pick = TRIM_W'($urandom_range(0, 32767));
                2: trim_pick = TRIM_W'($urandom_range(32768, 65535));
                3: trim_pick = TRIM_W'($urandom_range(0, 16383));
                4: trim_pick = TRIM_W'(32767);
                default: trim_pick = TRIM_W'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 7) == 0) begin
                count_data = CFG_W'($urandom_range(17, 200));
            end else begin
                count_data = CFG_W'($urandom_range(2, 16));
            end
            count_data[CFG_W-1:CNT_W] = ($urandom_range(0, 3) == 0) ?
                                        3'($urandom_range(1, 7)) : 3'b000;
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_TRIM, trim_pick);
                write_reg(REG_COUNT, count_data);
            end else begin
                write_reg(REG_COUNT, count_data);
                write_reg(REG_TRIM, trim_pick);
            end
            n = int'(set_size());
            nsets = (n > 16) ? 1 : $urandom_range(1, 5);
            repeat (nsets) begin
                push_samples(n);
                rand_items += n;
            end
            if ($urandom_range(0, 7) == 0) begin
                push_samples($urandom_range(1, n - 1));
            end
            drain();
        end

        drain();
        $display("Sent %0d samples under %0d register writes; checked %0d variances,",
                 samples_sent, reg_writes, sets_checked);
        $display("%0d of them fully trimmed, with random stalls on both channels.",
                 full_results);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Give up if the block stops answering.
    initial begin
        #(TIMEOUT_UNITS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
